// ===== rtl/das_pkg.sv =====
package das_pkg;

   // Width of every sample, coefficient and result on the ports.
   localparam int SAMPLE_BITS = 32;

   // Internal values are signed 64-bit words held within +-(2^62 - 1).
   localparam int VAL_BITS = 64;
   localparam int WIDE_BITS = VAL_BITS + 1;

   // Full magnitude product of two internal values, before scaling.
   localparam int PROD_BITS = 126;

   // Register stages inside one scaled multiplier.
   localparam int MUL_STAGES = 3;

   typedef logic signed [VAL_BITS-1:0] val_type;

   localparam val_type LIM = 64'sh3FFF_FFFF_FFFF_FFFF;
   localparam logic signed [WIDE_BITS-1:0] LIM_WIDE = 65'sh0_3FFF_FFFF_FFFF_FFFF;
   localparam logic signed [WIDE_BITS-1:0] NEG_LIM_WIDE = -LIM_WIDE;

   localparam logic signed [WIDE_BITS-1:0] SAMPLE_MAX =
      (65'sd1 <<< (SAMPLE_BITS - 1)) - 65'sd1;
   localparam logic signed [WIDE_BITS-1:0] SAMPLE_MIN = -SAMPLE_MAX - 65'sd1;

   // Faces of the cell, in the order the fluxes are formed.
   localparam int FACE_E = 0;
   localparam int FACE_W = 1;
   localparam int FACE_N = 2;
   localparam int FACE_S = 3;
   localparam int NUM_FACES = 4;

   typedef enum logic [2:0] {
      CSR_DIFF_XX  = 3'd0,
      CSR_DIFF_XY  = 3'd1,
      CSR_DIFF_YX  = 3'd2,
      CSR_DIFF_YY  = 3'd3,
      CSR_DRIFT_X  = 3'd4,
      CSR_DRIFT_Y  = 3'd5,
      CSR_INV_STEP = 3'd6
   } csr_index_type;

   typedef struct packed {
      logic signed [SAMPLE_BITS-1:0] centre;
      logic signed [SAMPLE_BITS-1:0] east;
      logic signed [SAMPLE_BITS-1:0] west;
      logic signed [SAMPLE_BITS-1:0] north;
      logic signed [SAMPLE_BITS-1:0] south;
      logic signed [SAMPLE_BITS-1:0] north_east;
      logic signed [SAMPLE_BITS-1:0] north_west;
      logic signed [SAMPLE_BITS-1:0] south_east;
      logic signed [SAMPLE_BITS-1:0] south_west;
   } req_type;

   typedef struct packed {
      logic signed [SAMPLE_BITS-1:0] rate_of_change;
      logic                          saturated;
   } rsp_type;

   typedef struct packed {
      logic    clip;
      val_type v;
   } clamp_type;

   // Pair sums, gradients and cross differences for the four faces.
   typedef struct packed {
      val_type [NUM_FACES-1:0] pair;
      val_type [NUM_FACES-1:0] grad;
      val_type [NUM_FACES-1:0] cross_diff;
      logic                    clip;
   } front_type;

   function automatic clamp_type clamp_wide(input logic signed [WIDE_BITS-1:0] x);
      clamp_type r;
      r.clip = 1'b0;
      r.v    = x[VAL_BITS-1:0];
      if (x > LIM_WIDE) begin
         r.clip = 1'b1;
         r.v    = LIM;
      end else if (x < NEG_LIM_WIDE) begin
         r.clip = 1'b1;
         r.v    = -LIM;
      end
      return r;
   endfunction

   function automatic clamp_type sadd(input val_type a, input val_type b);
      logic signed [WIDE_BITS-1:0] s;
      s = $signed({a[VAL_BITS-1], a}) + $signed({b[VAL_BITS-1], b});
      return clamp_wide(s);
   endfunction

   function automatic clamp_type ssub(input val_type a, input val_type b);
      logic signed [WIDE_BITS-1:0] s;
      s = $signed({a[VAL_BITS-1], a}) - $signed({b[VAL_BITS-1], b});
      return clamp_wide(s);
   endfunction

   function automatic clamp_type sext(input logic [SAMPLE_BITS-1:0] raw);
      logic signed [WIDE_BITS-1:0] s;
      s = $signed({{(WIDE_BITS - SAMPLE_BITS){raw[SAMPLE_BITS-1]}}, raw});
      return clamp_wide(s);
   endfunction

endpackage

// ===== rtl/das_mul.sv =====
module das_mul #(
   parameter int SHIFT = 16
) (
   input  logic                              clock,
   input  logic [das_pkg::MUL_STAGES-1:0]    en,
   input  das_pkg::val_type                  a,
   input  das_pkg::val_type                  b,
   output das_pkg::val_type                  prod,
   output logic                              clip
);
   import das_pkg::*;

   localparam int HALF = 32;

   logic [VAL_BITS-1:0]      ua;
   logic [VAL_BITS-1:0]      ub;
   logic [2*HALF-1:0]        p00_in, p00_ff;
   logic [2*HALF-2:0]        p01_in, p01_ff;
   logic [2*HALF-2:0]        p10_in, p10_ff;
   logic [2*HALF-3:0]        p11_in, p11_ff;
   logic                     neg_in, neg1_ff, neg2_ff;
   logic [PROD_BITS-1:0]     full_in, full_ff;
   logic [PROD_BITS-1:0]     rnd;
   logic [PROD_BITS-1:0]     mag;
   val_type                  mag_lim;
   val_type                  prod_in, prod_ff;
   logic                     clip_in, clip_ff;

   // First stage: magnitudes split into 32/31-bit halves, four partial products.
   always_comb begin
      ua     = a[VAL_BITS-1] ? VAL_BITS'(-a) : VAL_BITS'(a);
      ub     = b[VAL_BITS-1] ? VAL_BITS'(-b) : VAL_BITS'(b);
      neg_in = a[VAL_BITS-1] ^ b[VAL_BITS-1];
      p00_in = (2*HALF)'((2*HALF)'(ua[HALF-1:0]) * (2*HALF)'(ub[HALF-1:0]));
      p01_in = (2*HALF-1)'((2*HALF)'(ua[HALF-1:0]) * (2*HALF)'(ub[2*HALF-2:HALF]));
      p10_in = (2*HALF-1)'((2*HALF)'(ua[2*HALF-2:HALF]) * (2*HALF)'(ub[HALF-1:0]));
      p11_in = (2*HALF-2)'((2*HALF)'(ua[2*HALF-2:HALF]) * (2*HALF)'(ub[2*HALF-2:HALF]));
   end

   // Second stage: partial products summed into the full product.
   assign full_in = PROD_BITS'(p00_ff)
                  + (PROD_BITS'(p01_ff) << HALF)
                  + (PROD_BITS'(p10_ff) << HALF)
                  + (PROD_BITS'(p11_ff) << (2 * HALF));

   // Third stage: round half away from zero, scale, limit and restore the sign.
   always_comb begin
      rnd     = full_ff + (PROD_BITS'(1) << (SHIFT - 1));
      mag     = rnd >> SHIFT;
      clip_in = |mag[PROD_BITS-1:VAL_BITS-2];
      mag_lim = clip_in ? LIM : $signed({2'b00, mag[VAL_BITS-3:0]});
      prod_in = neg2_ff ? -mag_lim : mag_lim;
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         p00_ff  <= p00_in;
         p01_ff  <= p01_in;
         p10_ff  <= p10_in;
         p11_ff  <= p11_in;
         neg1_ff <= neg_in;
      end
      if (en[1]) begin
         full_ff <= full_in;
         neg2_ff <= neg1_ff;
      end
      if (en[2]) begin
         prod_ff <= prod_in;
         clip_ff <= clip_in;
      end
   end

   assign prod = prod_ff;
   assign clip = clip_ff;

endmodule

// ===== rtl/das_front.sv =====
module das_front (
   input  logic                 clock,
   input  logic [1:0]           en,
   input  das_pkg::req_type     req_data,
   input  logic                 cfg_clip,
   output das_pkg::front_type   front
);
   import das_pkg::*;

   localparam int NUM_PART = 2 * NUM_FACES;

   clamp_type                    c, e, w, n, s, ne, nw, se, sw;
   clamp_type [NUM_FACES-1:0]    pair_c, grad_c, cross_c;
   clamp_type [NUM_PART-1:0]     part_c;
   val_type   [NUM_FACES-1:0]    pair_in, pair_ff, grad_in, grad_ff;
   val_type   [NUM_PART-1:0]     part_in, part_ff;
   logic                         clip_in, clip_ff;
   front_type                    front_in, front_ff;

   always_comb begin
      c  = sext(req_data.centre);
      e  = sext(req_data.east);
      w  = sext(req_data.west);
      n  = sext(req_data.north);
      s  = sext(req_data.south);
      ne = sext(req_data.north_east);
      nw = sext(req_data.north_west);
      se = sext(req_data.south_east);
      sw = sext(req_data.south_west);

      pair_c[FACE_E] = sadd(c.v, e.v);
      pair_c[FACE_W] = sadd(c.v, w.v);
      pair_c[FACE_N] = sadd(c.v, n.v);
      pair_c[FACE_S] = sadd(c.v, s.v);
      grad_c[FACE_E] = ssub(e.v, c.v);
      grad_c[FACE_W] = ssub(c.v, w.v);
      grad_c[FACE_N] = ssub(n.v, c.v);
      grad_c[FACE_S] = ssub(c.v, s.v);

      // Each face's cross difference is part[2f] - part[2f+1].
      part_c[2*FACE_E]   = sadd(ne.v, n.v);
      part_c[2*FACE_E+1] = sadd(se.v, s.v);
      part_c[2*FACE_W]   = sadd(nw.v, n.v);
      part_c[2*FACE_W+1] = sadd(sw.v, s.v);
      part_c[2*FACE_N]   = sadd(ne.v, e.v);
      part_c[2*FACE_N+1] = sadd(nw.v, w.v);
      part_c[2*FACE_S]   = sadd(se.v, e.v);
      part_c[2*FACE_S+1] = sadd(sw.v, w.v);

      clip_in = cfg_clip | c.clip | e.clip | w.clip | n.clip | s.clip
              | ne.clip | nw.clip | se.clip | sw.clip;
      for (int f = 0; f < NUM_FACES; f++) begin
         pair_in[f] = pair_c[f].v;
         grad_in[f] = grad_c[f].v;
         clip_in    = clip_in | pair_c[f].clip | grad_c[f].clip;
      end
      for (int p = 0; p < NUM_PART; p++) begin
         part_in[p] = part_c[p].v;
         clip_in    = clip_in | part_c[p].clip;
      end
   end

   always_comb begin
      front_in.pair = pair_ff;
      front_in.grad = grad_ff;
      front_in.clip = clip_ff;
      for (int f = 0; f < NUM_FACES; f++) begin
         cross_c[f]             = ssub(part_ff[2*f], part_ff[2*f+1]);
         front_in.cross_diff[f] = cross_c[f].v;
         front_in.clip          = front_in.clip | cross_c[f].clip;
      end
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         pair_ff <= pair_in;
         grad_ff <= grad_in;
         part_ff <= part_in;
         clip_ff <= clip_in;
      end
      if (en[1]) begin
         front_ff <= front_in;
      end
   end

   assign front = front_ff;

endmodule

// ===== rtl/diffusion_advection_stencil_2d_unit.sv =====
// Rate of change of the centre sample of a 3x3 neighbourhood under anisotropic
// diffusion with advection, in signed fixed point with FRAC_BITS fraction bits.
//
// Request channel: req_valid, req_stall and req_data carry the nine samples of one
// neighbourhood; a transaction completes at a rising edge with req_valid high and
// req_stall low. Response channel: rsp_valid, rsp_stall and rsp_data carry the
// saturated rate and a flag that is set when any clamp acted on the way.
// Configuration: a write with csr_wr_en high stores csr_data into the register
// selected by csr_index; an index beyond the list is ignored. Write only while
// no transaction is in flight.
//
// The path runs through two front-end stages for the sums and differences,
// three scaled multiplies of three stages each, and the adds between them.
// One transaction may enter every cycle while req_stall is low. Reset is
// synchronous: it empties the pipeline and restores the registers (inverse step
// to one, the rest to zero). When the receiver stalls, data backs up only until
// the bubbles in the pipeline are filled, after which req_stall rises.
module diffusion_advection_stencil_2d_unit #(
   parameter int FRAC_BITS = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  das_pkg::req_type                  req_data,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output das_pkg::rsp_type                  rsp_data,
   input  logic                              csr_wr_en,
   input  logic [2:0]                        csr_index,
   input  logic [das_pkg::SAMPLE_BITS-1:0]   csr_data
);
   import das_pkg::*;

   // Stage map of the pipeline.
   localparam int ST_FRONT   = 0;
   localparam int ST_MUL1    = 2;
   localparam int ST_DIF     = ST_MUL1 + MUL_STAGES;
   localparam int ST_MUL2    = ST_DIF + 1;
   localparam int ST_FLUX    = ST_MUL2 + MUL_STAGES;
   localparam int ST_DIFF    = ST_FLUX + 1;
   localparam int ST_TOT     = ST_DIFF + 1;
   localparam int ST_MUL3    = ST_TOT + 1;
   localparam int ST_OUT     = ST_MUL3 + MUL_STAGES;
   localparam int NUM_STAGES = ST_OUT + 1;

   localparam logic [SAMPLE_BITS-1:0] INV_RESET = SAMPLE_BITS'(1) << FRAC_BITS;

   // Configuration registers.
   logic [SAMPLE_BITS-1:0] diff_xx_ff, diff_xy_ff, diff_yx_ff, diff_yy_ff;
   logic [SAMPLE_BITS-1:0] drift_x_ff, drift_y_ff, inv_step_ff;
   clamp_type              dxx, dxy, dyx, dyy, cx, cy, inv;
   logic                   cfg_clip;

   // Pipeline control: one valid bit per stage, and a stage loads when it is
   // empty or the stage after it loads too.
   logic [NUM_STAGES-1:0]  v_ff, v_in, en;

   front_type              front;

   val_type [NUM_FACES-1:0] adv_p, main_p, cross_p, m_p;
   logic    [NUM_FACES-1:0] adv_clip, main_clip, cross_clip, m_clip;
   clamp_type [NUM_FACES-1:0] dif_c, flux_c;
   val_type [NUM_FACES-1:0] dif_in, dif_ff, adv5_ff, adv6_ff, adv7_ff, adv8_ff;
   val_type [NUM_FACES-1:0] flux_in, flux_ff;
   logic                   dif_clip, flux_clip;
   clamp_type              dx_c, dy_c, tot_c;
   val_type                dx_ff, dy_ff, tot_ff;
   val_type                res_p;
   logic                   res_clip;
   logic signed [WIDE_BITS-1:0] res_wide, res_sat;
   logic                   fin_clip;
   rsp_type                rsp_in, rsp_ff;
   logic                   clip_ff [ST_MUL1:ST_OUT-1];

   // ------------------------------------------------------------------
   // Configuration port.
   // ------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         diff_xx_ff  <= '0;
         diff_xy_ff  <= '0;
         diff_yx_ff  <= '0;
         diff_yy_ff  <= '0;
         drift_x_ff  <= '0;
         drift_y_ff  <= '0;
         inv_step_ff <= INV_RESET;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_DIFF_XX:  diff_xx_ff  <= csr_data;
            CSR_DIFF_XY:  diff_xy_ff  <= csr_data;
            CSR_DIFF_YX:  diff_yx_ff  <= csr_data;
            CSR_DIFF_YY:  diff_yy_ff  <= csr_data;
            CSR_DRIFT_X:  drift_x_ff  <= csr_data;
            CSR_DRIFT_Y:  drift_y_ff  <= csr_data;
            CSR_INV_STEP: inv_step_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // The registers must change only while the pipeline is empty; the block
   // does not enforce it, and every stage reads them directly. Their range
   // clamps join the flag of each transaction at the first stage.
   always_comb begin
      dxx      = sext(diff_xx_ff);
      dxy      = sext(diff_xy_ff);
      dyx      = sext(diff_yx_ff);
      dyy      = sext(diff_yy_ff);
      cx       = sext(drift_x_ff);
      cy       = sext(drift_y_ff);
      inv      = sext(inv_step_ff);
      cfg_clip = dxx.clip | dxy.clip | dyx.clip | dyy.clip | cx.clip | cy.clip | inv.clip;
   end

   // ------------------------------------------------------------------
   // Handshake and valid bits.
   // ------------------------------------------------------------------
   genvar g;
   generate
      for (g = 0; g < NUM_STAGES; g++) begin : gen_en
         // A stage can load unless it and every stage after it is full and
         // the response is held.
         assign en[g] = !rsp_stall || !(&v_ff[NUM_STAGES-1:g]);
      end
   endgenerate

   assign v_in      = {v_ff[NUM_STAGES-2:0], req_valid};
   assign req_stall = !en[ST_FRONT];

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         for (int i = 0; i < NUM_STAGES; i++) begin
            if (en[i]) begin
               v_ff[i] <= v_in[i];
            end
         end
      end
   end

   // ------------------------------------------------------------------
   // Front end: range clamps, pair sums, gradients and cross differences.
   // ------------------------------------------------------------------
   das_front u_front (
      .clock    (clock),
      .en       (en[ST_FRONT+1:ST_FRONT]),
      .req_data (req_data),
      .cfg_clip (cfg_clip),
      .front    (front)
   );

   // ------------------------------------------------------------------
   // Per-face products: advection, main-axis diffusion and the cross term,
   // whose extra two bits of scaling give the one-quarter weight.
   // ------------------------------------------------------------------
   generate
      for (g = 0; g < NUM_FACES; g++) begin : gen_face
         localparam bit X_FACE = (g == FACE_E) || (g == FACE_W);

         das_mul #(.SHIFT(FRAC_BITS)) u_adv (
            .clock (clock),
            .en    (en[ST_MUL1+MUL_STAGES-1:ST_MUL1]),
            .a     (X_FACE ? cx.v : cy.v),
            .b     (front.pair[g]),
            .prod  (adv_p[g]),
            .clip  (adv_clip[g])
         );

         das_mul #(.SHIFT(FRAC_BITS)) u_main (
            .clock (clock),
            .en    (en[ST_MUL1+MUL_STAGES-1:ST_MUL1]),
            .a     (X_FACE ? dxx.v : dyy.v),
            .b     (front.grad[g]),
            .prod  (main_p[g]),
            .clip  (main_clip[g])
         );

         das_mul #(.SHIFT(FRAC_BITS + 2)) u_cross (
            .clock (clock),
            .en    (en[ST_MUL1+MUL_STAGES-1:ST_MUL1]),
            .a     (X_FACE ? dxy.v : dyx.v),
            .b     (front.cross_diff[g]),
            .prod  (cross_p[g]),
            .clip  (cross_clip[g])
         );

         // The diffusion sum is scaled by the inverse step.
         das_mul #(.SHIFT(FRAC_BITS)) u_inv (
            .clock (clock),
            .en    (en[ST_MUL2+MUL_STAGES-1:ST_MUL2]),
            .a     (inv.v),
            .b     (dif_ff[g]),
            .prod  (m_p[g]),
            .clip  (m_clip[g])
         );
      end
   endgenerate

   // Diffusion sum per face; the advection product waits alongside.
   always_comb begin
      dif_clip = 1'b0;
      for (int f = 0; f < NUM_FACES; f++) begin
         dif_c[f]  = sadd(main_p[f], cross_p[f]);
         dif_in[f] = dif_c[f].v;
         dif_clip  = dif_clip | dif_c[f].clip;
      end
   end

   // Face flux: advection plus scaled diffusion.
   always_comb begin
      flux_clip = 1'b0;
      for (int f = 0; f < NUM_FACES; f++) begin
         flux_c[f]  = sadd(adv8_ff[f], m_p[f]);
         flux_in[f] = flux_c[f].v;
         flux_clip  = flux_clip | flux_c[f].clip;
      end
   end

   // Divergence of the fluxes: east minus west and north minus south, summed.
   always_comb begin
      dx_c  = ssub(flux_ff[FACE_E], flux_ff[FACE_W]);
      dy_c  = ssub(flux_ff[FACE_N], flux_ff[FACE_S]);
      tot_c = sadd(dx_ff, dy_ff);
   end

   das_mul #(.SHIFT(FRAC_BITS)) u_res (
      .clock (clock),
      .en    (en[ST_MUL3+MUL_STAGES-1:ST_MUL3]),
      .a     (inv.v),
      .b     (tot_ff),
      .prod  (res_p),
      .clip  (res_clip)
   );

   // Final clamp into the sample range.
   always_comb begin
      res_wide = $signed({res_p[VAL_BITS-1], res_p});
      res_sat  = res_wide;
      fin_clip = 1'b0;
      if (res_wide > SAMPLE_MAX) begin
         res_sat  = SAMPLE_MAX;
         fin_clip = 1'b1;
      end else if (res_wide < SAMPLE_MIN) begin
         res_sat  = SAMPLE_MIN;
         fin_clip = 1'b1;
      end
      rsp_in.rate_of_change = res_sat[SAMPLE_BITS-1:0];
      rsp_in.saturated      = clip_ff[ST_OUT-1] | res_clip | fin_clip;
   end

   // ------------------------------------------------------------------
   // Data and flag registers. The flag of each transaction gathers every
   // clamp on its way; it rides through the multiplier stages unchanged and
   // takes the multiplier clamps as they leave.
   // ------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (en[ST_MUL1]) begin
         clip_ff[ST_MUL1] <= front.clip;
      end
      for (int i = ST_MUL1 + 1; i < ST_DIF; i++) begin
         if (en[i]) begin
            clip_ff[i] <= clip_ff[i-1];
         end
      end
      if (en[ST_DIF]) begin
         dif_ff           <= dif_in;
         adv5_ff          <= adv_p;
         clip_ff[ST_DIF]  <= clip_ff[ST_DIF-1] | (|adv_clip) | (|main_clip)
                           | (|cross_clip) | dif_clip;
      end
      for (int i = ST_MUL2; i < ST_FLUX; i++) begin
         if (en[i]) begin
            clip_ff[i] <= clip_ff[i-1];
         end
      end
      if (en[ST_MUL2]) begin
         adv6_ff <= adv5_ff;
      end
      if (en[ST_MUL2+1]) begin
         adv7_ff <= adv6_ff;
      end
      if (en[ST_MUL2+2]) begin
         adv8_ff <= adv7_ff;
      end
      if (en[ST_FLUX]) begin
         flux_ff          <= flux_in;
         clip_ff[ST_FLUX] <= clip_ff[ST_FLUX-1] | (|m_clip) | flux_clip;
      end
      if (en[ST_DIFF]) begin
         dx_ff            <= dx_c.v;
         dy_ff            <= dy_c.v;
         clip_ff[ST_DIFF] <= clip_ff[ST_DIFF-1] | dx_c.clip | dy_c.clip;
      end
      if (en[ST_TOT]) begin
         tot_ff          <= tot_c.v;
         clip_ff[ST_TOT] <= clip_ff[ST_TOT-1] | tot_c.clip;
      end
      for (int i = ST_MUL3; i < ST_OUT; i++) begin
         if (en[i]) begin
            clip_ff[i] <= clip_ff[i-1];
         end
      end
      if (en[ST_OUT]) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = v_ff[ST_OUT];
   assign rsp_data  = rsp_ff;

   // ------------------------------------------------------------------
   // Assertions.
   // ------------------------------------------------------------------

   // With every stage full and the response held, no request may be taken.
   a_full_blocks: assert property (@(posedge clock) disable iff (reset)
      ((&v_ff) && rsp_stall) |-> req_stall)
      else $error("request taken while pipeline full and response held");

   // An empty output stage means the whole pipeline moves.
   a_empty_out_moves: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> !req_stall)
      else $error("request stalled with an empty output stage");

   // A request that is taken occupies the first stage on the next cycle.
   a_enter: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> v_ff[ST_FRONT])
      else $error("accepted transaction lost at pipeline entry");

   // A clamp in the final scaling by the inverse step must show up in the
   // flag of the response that it belongs to.
   a_flag_on_clip: assert property (@(posedge clock) disable iff (reset)
      (en[ST_OUT] && v_ff[ST_OUT-1] && res_clip) |=> rsp_data.saturated)
      else $error("multiplier clamp not reported in saturation flag");

endmodule
